// File: hdl/scpg_pkg.sv
`timescale 1ns / 1ps

package scpg_pkg;

  // Input actions
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_EDGE = 2'd2;

  // Reply codes
  localparam logic [2:0] REPLY_DONE    = 3'd0;
  localparam logic [2:0] REPLY_ENDSTOP = 3'd1;
  localparam logic [2:0] REPLY_FRAME   = 3'd2;
  localparam logic [2:0] REPLY_OVERRUN = 3'd3;
  localparam logic [2:0] REPLY_DROPPED = 3'd4;

  // Configuration register indexes and reset values
  localparam logic REG_PULSE = 1'b0;
  localparam logic REG_HOLD  = 1'b1;
  localparam logic [7:0]  PULSE_RST = 8'd5;
  localparam logic [15:0] HOLD_RST  = 16'd1900;

  // Most replies one input can produce
  localparam int MAX_REPLIES = 4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] rx_byte;
    logic       frame_error;
    logic       overrun_error;
    logic       dropped_error;
    logic [2:0] endstop_level;
  } in_t;

  typedef struct packed {
    logic       step_pin;
    logic       dir_pin;
    logic       x_enable;
    logic       y_enable;
    logic       z_enable;
    logic       spindle_on;
    logic       reply_valid;
    logic [2:0] reply_code;
    logic       last;
  } out_t;

  // One handled input: pin levels plus its reply list
  typedef struct packed {
    logic                             step_pin;
    logic                             dir_pin;
    logic [2:0]                       enables;
    logic                             spindle_on;
    logic [2:0]                       rep_cnt;
    logic [MAX_REPLIES-1:0][2:0]      codes;
  } rec_t;

endpackage

// File: hdl/scpg_front.sv
`timescale 1ns / 1ps

module scpg_front import scpg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  in_t         in_item,
  input  logic [7:0]  pulse_ticks,
  input  logic [15:0] hold_ticks,
  output rec_t        rec
);

  localparam logic [1:0] MODE_WAIT1 = 2'd0;
  localparam logic [1:0] MODE_WAIT2 = 2'd1;
  localparam logic [1:0] MODE_STEP  = 2'd2;
  localparam logic [1:0] MODE_BACK  = 2'd3;

  logic [1:0]  mode_r, mode_nxt;
  logic [1:0]  resume_r, resume_nxt;
  logic [7:0]  first_r, first_nxt;
  logic [12:0] steps_r, steps_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic        low_r, low_nxt;
  logic        step_r, step_nxt;
  logic        dir_r, dir_nxt;
  logic [2:0]  en_r, en_nxt;
  logic        spin_r, spin_nxt;

  logic [2:0]                  rc;
  logic [MAX_REPLIES-1:0][2:0] codes;
  logic [15:0]                 timer_inc;
  logic                        step_end;
  logic [12:0]                 steps_dec;
  logic [12:0]                 cmd_steps;

  // Next-state logic for one accepted item
  always_comb begin
    mode_nxt   = mode_r;
    resume_nxt = resume_r;
    first_nxt  = first_r;
    steps_nxt  = steps_r;
    timer_nxt  = timer_r;
    low_nxt    = low_r;
    step_nxt   = step_r;
    dir_nxt    = dir_r;
    en_nxt     = en_r;
    spin_nxt   = spin_r;
    rc         = 3'd0;
    codes      = '0;
    step_end   = 1'b0;
    timer_inc  = (timer_r == 16'hFFFF) ? timer_r : timer_r + 16'd1;
    steps_dec  = steps_r - 13'd1;
    cmd_steps  = {first_r[4:0], in_item.rx_byte};

    case (in_item.action)
      ACT_BYTE: begin
        if (mode_r == MODE_WAIT1 || mode_r == MODE_WAIT2) begin
          if (in_item.frame_error) begin
            codes[rc[1:0]] = REPLY_FRAME;
            rc = rc + 3'd1;
          end
          if (in_item.overrun_error) begin
            codes[rc[1:0]] = REPLY_OVERRUN;
            rc = rc + 3'd1;
          end
          if (in_item.dropped_error) begin
            codes[rc[1:0]] = REPLY_DROPPED;
            rc = rc + 3'd1;
          end
          if (mode_r == MODE_WAIT1) begin
            first_nxt = in_item.rx_byte;
            mode_nxt  = MODE_WAIT2;
          end else begin
            case (first_r[7:6])
              2'b10:   en_nxt = 3'b001;
              2'b01:   en_nxt = 3'b010;
              2'b11:   en_nxt = 3'b100;
              default: spin_nxt = ~spin_r;
            endcase
            dir_nxt = first_r[5];
            if (cmd_steps == 13'd0) begin
              // empty command finishes at once
              en_nxt    = 3'b000;
              steps_nxt = 13'd0;
              step_nxt  = 1'b1;
              low_nxt   = 1'b0;
              timer_nxt = 16'd0;
              mode_nxt  = MODE_WAIT1;
              codes[rc[1:0]] = REPLY_DONE;
              rc = rc + 3'd1;
            end else begin
              steps_nxt = cmd_steps;
              mode_nxt  = MODE_STEP;
              step_nxt  = 1'b0;
              low_nxt   = 1'b1;
              timer_nxt = 16'd0;
            end
          end
        end
      end
      ACT_TICK: begin
        if (mode_r == MODE_STEP || mode_r == MODE_BACK) begin
          // pulse timing: low phase then high phase
          timer_nxt = timer_inc;
          if (low_r) begin
            if (timer_inc >= {8'd0, pulse_ticks}) begin
              step_nxt  = 1'b1;
              low_nxt   = 1'b0;
              timer_nxt = 16'd0;
            end
          end else if (timer_inc >= hold_ticks) begin
            timer_nxt = 16'd0;
            step_end  = 1'b1;
          end
          if (step_end) begin
            if (mode_r == MODE_STEP) begin
              steps_nxt = steps_dec;
              if (steps_dec == 13'd0) begin
                en_nxt   = 3'b000;
                step_nxt = 1'b1;
                low_nxt  = 1'b0;
                mode_nxt = MODE_WAIT1;
                codes[rc[1:0]] = REPLY_DONE;
                rc = rc + 3'd1;
              end else begin
                step_nxt = 1'b0;
                low_nxt  = 1'b1;
              end
            end else if (in_item.endstop_level != 3'd0) begin
              step_nxt = 1'b0;
              low_nxt  = 1'b1;
            end else begin
              // back-off over: resume, finishing an interrupted command
              steps_nxt = 13'd0;
              step_nxt  = 1'b1;
              low_nxt   = 1'b0;
              mode_nxt  = resume_r;
              if (resume_r == MODE_STEP) begin
                en_nxt   = 3'b000;
                mode_nxt = MODE_WAIT1;
                codes[rc[1:0]] = REPLY_DONE;
                rc = rc + 3'd1;
              end
            end
          end
        end
      end
      ACT_EDGE: begin
        if (mode_r != MODE_BACK) begin
          codes[rc[1:0]] = REPLY_ENDSTOP;
          rc = rc + 3'd1;
          dir_nxt    = 1'b0;
          resume_nxt = mode_r;
          timer_nxt  = 16'd0;
          if (in_item.endstop_level != 3'd0) begin
            mode_nxt = MODE_BACK;
            step_nxt = 1'b0;
            low_nxt  = 1'b1;
          end else begin
            steps_nxt = 13'd0;
            step_nxt  = 1'b1;
            low_nxt   = 1'b0;
            if (mode_r == MODE_STEP) begin
              en_nxt   = 3'b000;
              mode_nxt = MODE_WAIT1;
              codes[rc[1:0]] = REPLY_DONE;
              rc = rc + 3'd1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Record handed to the queue, taken along with the state update
  always_comb begin
    rec.step_pin   = step_nxt;
    rec.dir_pin    = dir_nxt;
    rec.enables    = en_nxt;
    rec.spindle_on = spin_nxt;
    rec.rep_cnt    = rc;
    rec.codes      = codes;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_WAIT1;
      resume_r <= MODE_WAIT1;
      first_r  <= 8'd0;
      steps_r  <= 13'd0;
      timer_r  <= 16'd0;
      low_r    <= 1'b0;
      step_r   <= 1'b1;
      dir_r    <= 1'b0;
      en_r     <= 3'b000;
      spin_r   <= 1'b0;
    end else if (push) begin
      mode_r   <= mode_nxt;
      resume_r <= resume_nxt;
      first_r  <= first_nxt;
      steps_r  <= steps_nxt;
      timer_r  <= timer_nxt;
      low_r    <= low_nxt;
      step_r   <= step_nxt;
      dir_r    <= dir_nxt;
      en_r     <= en_nxt;
      spin_r   <= spin_nxt;
    end
  end

endmodule

// File: hdl/scpg_queue.sv
`timescale 1ns / 1ps

module scpg_queue import scpg_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  rec_t push_rec,
  output logic full,
  input  logic pop,
  output logic not_empty,
  output rec_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  rec_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == CW'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rd_ptr_r];

  // Pointer wrap and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

// File: hdl/scpg_back.sv
`timescale 1ns / 1ps

module scpg_back import scpg_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_valid,
  input  rec_t q_head,
  output logic pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  rec_t       cur_r;
  logic       cur_valid_r;
  logic [1:0] idx_r;
  logic       out_valid_r;
  out_t       out_r;

  logic       adv;
  logic       is_last;
  logic [2:0] n_res;
  out_t       res;

  // Results for this record; a record with no replies still gives one
  assign n_res   = (cur_r.rep_cnt == 3'd0) ? 3'd1 : cur_r.rep_cnt;
  assign is_last = ({1'b0, idx_r} + 3'd1) == n_res;
  assign adv     = cur_valid_r && (!out_valid_r || !out_stall);
  assign pop     = q_valid && (!cur_valid_r || (adv && is_last));

  always_comb begin
    res.step_pin    = cur_r.step_pin;
    res.dir_pin     = cur_r.dir_pin;
    res.x_enable    = cur_r.enables[0];
    res.y_enable    = cur_r.enables[1];
    res.z_enable    = cur_r.enables[2];
    res.spindle_on  = cur_r.spindle_on;
    res.reply_valid = (cur_r.rep_cnt != 3'd0);
    res.reply_code  = (cur_r.rep_cnt != 3'd0) ? cur_r.codes[idx_r] : REPLY_DONE;
    res.last        = is_last;
  end

  // Record holder and result index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else if (pop) begin
      cur_valid_r <= 1'b1;
      idx_r       <= 2'd0;
    end else if (adv) begin
      cur_valid_r <= !is_last;
      idx_r       <= idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= q_head;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hdl/stepper_command_pulse_generator.sv
`timescale 1ns / 1ps
// Path: queue slot, then the back's record holder, then the output register.
// Throughput: one input per cycle into the front while the queue is not full;
//   the back emits one result per cycle unless stalled; 1 to 4 results per item.
// The queue between front and back holds QUEUE_DEPTH handled items.
// Reset (rst_n low, synchronous): waiting for a first byte, step pin high,
//   enables, direction and spindle low, queue and output empty, registers default.

module stepper_command_pulse_generator import scpg_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_t        out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0]  pulse_r;
  logic [15:0] hold_r;
  logic        cfg_wr;
  logic        push;
  logic        q_full;
  logic        q_valid;
  logic        pop;
  rec_t        front_rec;
  rec_t        q_head;

  // Configuration registers
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == REG_HOLD) ? {16'd0, hold_r} : {24'd0, pulse_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r <= PULSE_RST;
      hold_r  <= HOLD_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_PULSE) begin
        pulse_r <= cfg_pwdata[7:0];
      end else begin
        hold_r <= cfg_pwdata[15:0];
      end
    end
  end

  // Input transfer
  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  scpg_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_item     (in_data),
    .pulse_ticks (pulse_r),
    .hold_ticks  (hold_r),
    .rec         (front_rec)
  );

  scpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_rec  (front_rec),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  scpg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A result without a reply is the only result of its item
  a_noreply_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.reply_valid) |-> out_data.last)
    else $error("reply-less result not marked last");

  // A result without a reply carries code zero
  a_noreply_code: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.reply_valid) |-> (out_data.reply_code == REPLY_DONE))
    else $error("reply code set without reply");

  // The queue never takes a record when full, and never pops when empty
  a_queue_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && q_full) && !(pop && !q_valid))
    else $error("queue overflow or underflow");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import scpg_pkg::*;

  // Action code the block treats as a no-op
  localparam logic [1:0] ACT_NONE = 2'd3;

  // Axis select field, bits 7:6 of the first command byte
  localparam logic [1:0] SEL_X = 2'b10;
  localparam logic [1:0] SEL_Y = 2'b01;
  localparam logic [1:0] SEL_Z = 2'b11;

  // Random phases: timing registers, sender idle and receiver stall percentages
  localparam int NUM_PHASES  = 4;
  localparam int PHASE_ITEMS = 59;
  localparam int PHASE_PULSE [NUM_PHASES] = '{2, 0, 255, 1};
  localparam int PHASE_HOLD  [NUM_PHASES] = '{3, 0, 65535, 5};
  localparam int PHASE_IDLE  [NUM_PHASES] = '{0, 80, 0, 21};
  localparam int PHASE_STALL [NUM_PHASES] = '{0, 0, 80, 21};
  localparam int HOLD_OFF_CYCLES = 120;

  typedef enum logic [1:0] {WAIT_FIRST, WAIT_SECOND, STEPPING, BACKING_OFF} cmd_mode_e;
  typedef enum logic {ROW_ITEM, ROW_REG} row_kind_e;

  // One row of the directed table: an input transfer or a register write
  typedef struct packed {
    row_kind_e   kind;
    in_t         item;
    logic        typed;
    out_t        want;
    logic        reg_idx;
    logic [15:0] value;
  } plan_row_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_valid    = 1'b0;
  logic        in_stall;
  in_t         in_data     = '0;
  logic        out_valid;
  logic        out_stall   = 1'b0;
  out_t        out_data;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Pin-state predictor
  cmd_mode_e   mode_q    = WAIT_FIRST;
  cmd_mode_e   resume_q  = WAIT_FIRST;
  logic [7:0]  first_q   = '0;
  logic [12:0] steps_q   = '0;
  logic [15:0] timer_q   = '0;
  logic        low_q     = 1'b0;
  logic        step_q    = 1'b1;
  logic        dir_q     = 1'b0;
  logic [2:0]  en_q      = '0;
  logic        spin_q    = 1'b0;
  logic [7:0]  pulse_cfg = PULSE_RST;
  logic [15:0] hold_cfg  = HOLD_RST;
  logic [2:0]  pending_replies [$];
  out_t        expected_pins [$];

  int err_count      = 0;
  int items_accepted = 0;
  int items_acting   = 0;
  int results_seen   = 0;
  int replies_seen   = 0;
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  // Hold-off request: the sequence flips hold_off_tgl, the receiver tracks it
  logic hold_off_tgl  = 1'b0;
  logic hold_off_seen = 1'b0;
  int hold_off_left  = 0;

  plan_row_t directed_plan [27];

  stepper_command_pulse_generator dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic void add_reply(logic [2:0] code);
    if (pending_replies.size() < MAX_REPLIES) pending_replies.push_back(code);
  endfunction

  function automatic void begin_pulse();
    step_q  = 1'b0;
    low_q   = 1'b1;
    timer_q = '0;
  endfunction

  function automatic void close_command();
    en_q    = '0;
    steps_q = '0;
    step_q  = 1'b1;
    low_q   = 1'b0;
    timer_q = '0;
    mode_q  = WAIT_FIRST;
    add_reply(REPLY_DONE);
  endfunction

  // One tick of step timing; true when a full low + high step has ended
  function automatic bit advance_timer();
    if (timer_q != 16'hFFFF) timer_q++;
    if (low_q) begin
      if (timer_q >= pulse_cfg) begin
        step_q  = 1'b1;
        low_q   = 1'b0;
        timer_q = '0;
      end
      return 1'b0;
    end
    if (timer_q >= hold_cfg) begin
      timer_q = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void leave_backoff();
    steps_q = '0;
    step_q  = 1'b1;
    low_q   = 1'b0;
    timer_q = '0;
    mode_q  = resume_q;
    if (mode_q == STEPPING) close_command();
  endfunction

  // Update the predicted state for one accepted input and queue its results;
  // returns whether the input acted on the block at all
  function automatic bit predict_pins(in_t it);
    out_t r;
    bit   effective;
    int   n;
    pending_replies.delete();
    effective = 1'b0;
    if (it.action == ACT_BYTE && (mode_q == WAIT_FIRST || mode_q == WAIT_SECOND)) begin
      effective = 1'b1;
      if (it.frame_error) add_reply(REPLY_FRAME);
      if (it.overrun_error) add_reply(REPLY_OVERRUN);
      if (it.dropped_error) add_reply(REPLY_DROPPED);
      if (mode_q == WAIT_FIRST) begin
        first_q = it.rx_byte;
        mode_q  = WAIT_SECOND;
      end else begin
        case (first_q[7:6])
          SEL_X: en_q = 3'b001;
          SEL_Y: en_q = 3'b010;
          SEL_Z: en_q = 3'b100;
          default: spin_q = ~spin_q;
        endcase
        dir_q   = first_q[5];
        steps_q = {first_q[4:0], it.rx_byte};
        if (steps_q == '0) begin
          close_command();
        end else begin
          mode_q = STEPPING;
          begin_pulse();
        end
      end
    end else if (it.action == ACT_TICK && (mode_q == STEPPING || mode_q == BACKING_OFF)) begin
      effective = 1'b1;
      if (advance_timer()) begin
        if (mode_q == STEPPING) begin
          steps_q = steps_q - 13'd1;
          if (steps_q == '0) close_command();
          else begin_pulse();
        end else if (it.endstop_level != '0) begin
          begin_pulse();
        end else begin
          leave_backoff();
        end
      end
    end else if (it.action == ACT_EDGE && mode_q != BACKING_OFF) begin
      effective = 1'b1;
      add_reply(REPLY_ENDSTOP);
      dir_q    = 1'b0;
      resume_q = mode_q;
      if (it.endstop_level != '0) begin
        mode_q = BACKING_OFF;
        begin_pulse();
      end else begin
        leave_backoff();
      end
    end
    // Without a reply the input still yields one plain result
    n = (pending_replies.size() == 0) ? 1 : pending_replies.size();
    for (int k = 0; k < n; k++) begin
      r.step_pin    = step_q;
      r.dir_pin     = dir_q;
      r.x_enable    = en_q[0];
      r.y_enable    = en_q[1];
      r.z_enable    = en_q[2];
      r.spindle_on  = spin_q;
      r.reply_valid = (pending_replies.size() != 0);
      r.reply_code  = r.reply_valid ? pending_replies[k] : REPLY_DONE;
      r.last        = (k == n - 1);
      expected_pins.push_back(r);
    end
    return effective;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic plan_row_t stim(logic [1:0] act, logic [7:0] data, logic [2:0] errs,
                                     logic [2:0] ends);
    plan_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.item.action        = act;
    row.item.rx_byte       = data;
    row.item.frame_error   = errs[2];
    row.item.overrun_error = errs[1];
    row.item.dropped_error = errs[0];
    row.item.endstop_level = ends;
    return row;
  endfunction

  // Row with its single result written out: pins still at their reset levels
  function automatic plan_row_t stim_typed(logic [1:0] act, logic [7:0] data, logic [2:0] errs,
                                           logic [2:0] ends, logic rv, logic [2:0] code);
    plan_row_t row;
    row = stim(act, data, errs, ends);
    row.typed = 1'b1;
    row.want  = '0;
    row.want.step_pin    = 1'b1;
    row.want.reply_valid = rv;
    row.want.reply_code  = code;
    row.want.last        = 1'b1;
    return row;
  endfunction

  function automatic plan_row_t reg_row(logic idx, logic [15:0] value);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_REG;
    row.reg_idx = idx;
    row.value   = value;
    return row;
  endfunction

  // Mostly well-formed traffic for the current mode, with some noise
  function automatic in_t random_item();
    in_t it;
    int  roll;
    it   = in_t'(16'($urandom));
    roll = $urandom_range(99);
    if (roll < 10) return it;
    it.frame_error   = ($urandom_range(99) < 8);
    it.overrun_error = ($urandom_range(99) < 8);
    it.dropped_error = ($urandom_range(99) < 8);
    if (roll < 16) begin
      it.action        = ACT_EDGE;
      it.endstop_level = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, 1));
    end else if (mode_q == WAIT_FIRST) begin
      it.action  = ACT_BYTE;
      it.rx_byte = {2'($urandom), 1'($urandom),
                    ($urandom_range(99) < 85) ? 5'd0 : 5'($urandom)};
    end else if (mode_q == WAIT_SECOND) begin
      it.action  = ACT_BYTE;
      it.rx_byte = ($urandom_range(99) < 90) ? 8'($urandom_range(3)) : 8'($urandom);
    end else if (roll < 20) begin
      it.action = ACT_BYTE;
    end else begin
      it.action        = ACT_TICK;
      it.endstop_level = $urandom_range(1) ? 3'd0 : 3'($urandom_range(7, 1));
    end
    return it;
  endfunction

  // Offer one item, wait for its transfer, then predict its results
  task automatic send_item(input in_t it, output bit effective);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    effective = predict_pins(it);
    items_accepted++;
    if (effective) items_acting++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pins.size() != 0);
  endtask

  // Register write while idle: setup cycle, then access cycle
  task automatic write_reg(input logic idx, input logic [31:0] value);
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (idx == REG_PULSE) pulse_cfg = value[7:0];
    else hold_cfg = value[15:0];
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_off_tgl != hold_off_seen) begin
      hold_off_seen <= hold_off_tgl;
      hold_off_left <= HOLD_OFF_CYCLES;
      out_stall     <= 1'b1;
    end else if (hold_off_left > 0) begin
      hold_off_left <= hold_off_left - 1;
      out_stall     <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.reply_valid) replies_seen++;
      if (expected_pins.size() == 0) begin
        $error("result transfer with no expected result pending");
        err_count++;
      end else begin
        want = expected_pins.pop_front();
        check_field("step_pin", want.step_pin, out_data.step_pin);
        check_field("dir_pin", want.dir_pin, out_data.dir_pin);
        check_field("x_enable", want.x_enable, out_data.x_enable);
        check_field("y_enable", want.y_enable, out_data.y_enable);
        check_field("z_enable", want.z_enable, out_data.z_enable);
        check_field("spindle_on", want.spindle_on, out_data.spindle_on);
        check_field("reply_valid", want.reply_valid, out_data.reply_valid);
        check_field("reply_code", want.reply_code, out_data.reply_code);
        check_field("last", want.last, out_data.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int   acted;
    bit   eff;
    bit   held_off;
    bit   paused;
    out_t dummy;

    held_off = 1'b0;
    paused   = 1'b0;

    directed_plan = '{
      // reset timing: idle tick, unused action, end-stop with no pin, framing error
      stim_typed(ACT_TICK, 8'h00, 3'b000, 3'b000, 1'b0, REPLY_DONE),
      stim_typed(ACT_NONE, 8'hFF, 3'b111, 3'b111, 1'b0, REPLY_DONE),
      stim_typed(ACT_EDGE, 8'h00, 3'b000, 3'b000, 1'b1, REPLY_ENDSTOP),
      stim_typed(ACT_BYTE, 8'h00, 3'b100, 3'b000, 1'b1, REPLY_FRAME),
      // spindle toggle with zero count, then all errors and a full-scale X count
      stim(ACT_BYTE, 8'h00, 3'b011, 3'b000),
      stim(ACT_BYTE, 8'hBF, 3'b111, 3'b000),
      stim(ACT_BYTE, 8'hFF, 3'b000, 3'b000),
      stim(ACT_TICK, 8'h00, 3'b000, 3'b000),
      // byte ignored while busy, then end-stop with no pin ends the command
      stim(ACT_BYTE, 8'h55, 3'b100, 3'b000),
      stim(ACT_EDGE, 8'h00, 3'b000, 3'b000),
      reg_row(REG_PULSE, 16'd1),
      reg_row(REG_HOLD, 16'd1),
      // Y command, back-off while stepping, a further edge ignored during back-off
      stim(ACT_BYTE, 8'h40, 3'b000, 3'b000),
      stim(ACT_BYTE, 8'h02, 3'b000, 3'b000),
      stim(ACT_EDGE, 8'h00, 3'b000, 3'b100),
      stim(ACT_EDGE, 8'h00, 3'b000, 3'b111),
      stim(ACT_TICK, 8'h00, 3'b000, 3'b010),
      stim(ACT_TICK, 8'h00, 3'b000, 3'b010),
      stim(ACT_TICK, 8'h00, 3'b000, 3'b000),
      stim(ACT_TICK, 8'h00, 3'b000, 3'b000),
      // Z command of one step run to completion
      stim(ACT_BYTE, 8'hE0, 3'b000, 3'b000),
      stim(ACT_BYTE, 8'h01, 3'b000, 3'b000),
      stim(ACT_TICK, 8'h00, 3'b000, 3'b000),
      stim(ACT_TICK, 8'h00, 3'b000, 3'b000),
      // end-stop between the two bytes keeps the stored first byte
      stim(ACT_BYTE, 8'hC8, 3'b001, 3'b000),
      stim(ACT_EDGE, 8'h00, 3'b000, 3'b000),
      stim(ACT_BYTE, 8'h00, 3'b000, 3'b000)
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table
    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_REG) begin
        write_reg(directed_plan[i].reg_idx, 32'(directed_plan[i].value));
      end else begin
        send_item(directed_plan[i].item, eff);
        if (directed_plan[i].typed) begin
          dummy = expected_pins.pop_back();
          expected_pins.push_back(directed_plan[i].want);
        end
      end
    end

    // Random phases, each with its own timing and flow-control pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_reg(REG_PULSE, 32'(PHASE_PULSE[p]));
      write_reg(REG_HOLD, 32'(PHASE_HOLD[p]));
      send_idle_pct = PHASE_IDLE[p];
      stall_pct     = PHASE_STALL[p];
      acted = 0;
      while (acted < PHASE_ITEMS) begin
        if (p == 0 && acted == 10 && !held_off) begin
          // receiver holds off while the sender keeps offering transfers
          hold_off_tgl <= ~hold_off_tgl;
          held_off = 1'b1;
        end
        if (p == NUM_PHASES - 1 && acted == 30 && !paused) begin
          wait_drained();
          paused = 1'b1;
        end
        send_item(random_item(), eff);
        acted += eff;
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("Covered %0d input transfers (%0d acting on the block), %0d result transfers,",
             items_accepted, items_acting, results_seen);
    $display("%0d of them replies, under reset, minimum, zero and full-scale step timing.",
             replies_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
